// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge outside reset
`define AFK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that one condition implies another at the same edge
`define AFK_ASSERT_IMPL(lbl, pre, post, msg) \
	`AFK_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// ----- hw/rtl/afk_pkg.sv -----
// ----------------------------------------------------------------------------
// afk_pkg
// Constants, types and the arctangent table of the forward kinematics pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afk_pkg;

	localparam int CORDIC_STAGES = 18;
	localparam int N_ITER = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

	localparam int LANES = 4;
	localparam int L_T2 = 0;
	localparam int L_T23 = 1;
	localparam int L_T234 = 2;
	localparam int L_T5 = 3;

	localparam int IW = 19;
	localparam int AW = 21;
	localparam int RW = 18;
	localparam int CW = 33;
	localparam int QW = 18;
	localparam int LW = 24;
	localparam int PW = 26;
	localparam int MW = LW + QW;
	localparam int SW = MW + 2;
	localparam int RPW = 2 * QW;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FORE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOOL = 2'd3;

	localparam logic signed [LW-1:0] TOOL_LENGTH_RESET = 24'sd25600;

	localparam logic signed [AW-1:0] PI_Q = 21'sd205887;
	localparam logic signed [AW-1:0] TWO_PI_Q = 21'sd411775;
	localparam logic signed [AW-1:0] HALF_PI_Q = 21'sd102944;

	localparam logic signed [CW-1:0] GAIN_INV = 33'sd652032874;
	localparam logic signed [CW-1:0] CRD_HALF = 33'sd8192;
	localparam logic signed [CW-1:0] Q16_MAX = 33'sd65536;
	localparam logic signed [CW-1:0] Q16_MIN = -33'sd65536;

	localparam logic signed [RPW-1:0] RND_RP = 36'sd32768;
	localparam logic signed [SW-1:0] RND_SUM = 44'sd32768;
	localparam logic signed [SW-1:0] POS_MAX = 44'sd33554431;
	localparam logic signed [SW-1:0] POS_MIN = -44'sd33554432;

	typedef struct packed {
		logic signed [RW-1:0] ang;
		logic                 neg;
	} afk_lane_t;

	typedef struct packed {
		logic signed [LW-1:0] upper;
		logic signed [LW-1:0] fore;
		logic signed [LW-1:0] height;
		logic signed [LW-1:0] tool;
	} afk_cfg_t;

	function automatic logic signed [CW-1:0] atan_c(input int i);
		case (i)
			0: return 33'sd843314856;
			1: return 33'sd497837829;
			2: return 33'sd263043836;
			3: return 33'sd133525158;
			4: return 33'sd67021686;
			5: return 33'sd33543515;
			6: return 33'sd16775850;
			7: return 33'sd8388437;
			8: return 33'sd4194282;
			9: return 33'sd2097149;
			10: return 33'sd1048575;
			11: return 33'sd524287;
			12: return 33'sd262143;
			13: return 33'sd131071;
			14: return 33'sd65535;
			15: return 33'sd32767;
			16: return 33'sd16383;
			17: return 33'sd8191;
			18: return 33'sd4095;
			19: return 33'sd2047;
			20: return 33'sd1023;
			21: return 33'sd511;
			22: return 33'sd255;
			23: return 33'sd127;
			default: return '0;
		endcase
	endfunction

endpackage

// ----- hw/rtl/afk_prep.sv -----
// ----------------------------------------------------------------------------
// afk_prep
// Angle sums, range reduction and quadrant fold; lift plus height offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afk_prep (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_take,
	input  logic signed [afk_pkg::LW-1:0]   lift_height,
	input  logic signed [afk_pkg::IW-1:0]   shoulder_angle,
	input  logic signed [afk_pkg::IW-1:0]   elbow_angle,
	input  logic signed [afk_pkg::IW-1:0]   wrist_pitch_angle,
	input  logic signed [afk_pkg::IW-1:0]   wrist_roll_angle,
	input  logic signed [afk_pkg::LW-1:0]   height_offset,
	output logic                            vld_s2,
	output afk_pkg::afk_lane_t              lane_s2 [afk_pkg::LANES],
	output logic signed [afk_pkg::PW-1:0]   pz_s2
);
	import afk_pkg::*;

	logic                 vld_s1;
	logic signed [AW-1:0] ang_s1 [LANES];
	logic signed [PW-1:0] pz_s1;

	// fold around one wrap point; base is a constant multiple of two pi
	function automatic afk_lane_t fold(input logic signed [AW-1:0] a,
		input logic signed [AW-1:0] base);
		afk_lane_t            o;
		logic signed [AW-1:0] r;
		o.neg = 1'b1;
		if (a > base + HALF_PI_Q) begin
			r = a - (base + PI_Q);
		end else if (a < base - HALF_PI_Q) begin
			r = a - (base - PI_Q);
		end else begin
			r = a - base;
			o.neg = 1'b0;
		end
		o.ang = r[RW-1:0];
		return o;
	endfunction

	function automatic afk_lane_t reduce(input logic signed [AW-1:0] a);
		if (a > PI_Q + TWO_PI_Q) return fold(a, TWO_PI_Q + TWO_PI_Q);
		if (a > PI_Q) return fold(a, TWO_PI_Q);
		if (a < -(PI_Q + TWO_PI_Q)) return fold(a, -(TWO_PI_Q + TWO_PI_Q));
		if (a < -PI_Q) return fold(a, -TWO_PI_Q);
		return fold(a, '0);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1[L_T2]   <= AW'(shoulder_angle);
			ang_s1[L_T23]  <= AW'(shoulder_angle) + AW'(elbow_angle);
			ang_s1[L_T234] <= AW'(shoulder_angle) + AW'(elbow_angle) + AW'(wrist_pitch_angle);
			ang_s1[L_T5]   <= AW'(wrist_roll_angle);
			pz_s1          <= PW'(lift_height) + PW'(height_offset);
			for (int l = 0; l < LANES; l++) lane_s2[l] <= reduce(ang_s1[l]);
			pz_s2 <= pz_s1;
		end
	end

endmodule

// ----- hw/rtl/afk_cordic.sv -----
// ----------------------------------------------------------------------------
// afk_cordic
// Rotation-mode CORDIC, one iteration per stage, four angle lanes in parallel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afk_cordic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            vld_in,
	input  afk_pkg::afk_lane_t              lane_in [afk_pkg::LANES],
	input  logic signed [afk_pkg::PW-1:0]   pz_in,
	output logic                            vld_out,
	output logic [afk_pkg::LANES-1:0]       neg_out,
	output logic signed [afk_pkg::CW-1:0]   x_out [afk_pkg::LANES],
	output logic signed [afk_pkg::CW-1:0]   y_out [afk_pkg::LANES],
	output logic signed [afk_pkg::PW-1:0]   pz_out
);
	import afk_pkg::*;

	logic signed [CW-1:0] xi [N_ITER][LANES];
	logic signed [CW-1:0] yi [N_ITER][LANES];
	logic signed [CW-1:0] zi [N_ITER][LANES];
	logic signed [CW-1:0] cx_sn [N_ITER][LANES];
	logic signed [CW-1:0] cy_sn [N_ITER][LANES];
	logic signed [CW-1:0] cz_sn [N_ITER][LANES];
	logic [N_ITER-1:0]    vld_sn;
	logic [LANES-1:0]     neg_sn [N_ITER];
	logic signed [PW-1:0] pz_sn [N_ITER];

	for (genvar i = 0; i < N_ITER; i++) begin : g_stage
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			if (i == 0) begin : g_init
				assign xi[i][l] = GAIN_INV;
				assign yi[i][l] = '0;
				assign zi[i][l] = CW'(lane_in[l].ang) <<< 14;
			end else begin : g_chain
				assign xi[i][l] = cx_sn[i-1][l];
				assign yi[i][l] = cy_sn[i-1][l];
				assign zi[i][l] = cz_sn[i-1][l];
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					if (zi[i][l][CW-1]) begin
						cx_sn[i][l] <= xi[i][l] + (yi[i][l] >>> i);
						cy_sn[i][l] <= yi[i][l] - (xi[i][l] >>> i);
						cz_sn[i][l] <= zi[i][l] + atan_c(i);
					end else begin
						cx_sn[i][l] <= xi[i][l] - (yi[i][l] >>> i);
						cy_sn[i][l] <= yi[i][l] + (xi[i][l] >>> i);
						cz_sn[i][l] <= zi[i][l] - atan_c(i);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else if (adv) begin
			vld_sn <= {vld_sn[N_ITER-2:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) neg_sn[0][l] <= lane_in[l].neg;
			pz_sn[0] <= pz_in;
			for (int k = 1; k < N_ITER; k++) begin
				neg_sn[k] <= neg_sn[k-1];
				pz_sn[k]  <= pz_sn[k-1];
			end
		end
	end

	assign vld_out = vld_sn[N_ITER-1];
	assign neg_out = neg_sn[N_ITER-1];
	assign pz_out  = pz_sn[N_ITER-1];
	assign x_out   = cx_sn[N_ITER-1];
	assign y_out   = cy_sn[N_ITER-1];

endmodule

// ----- hw/rtl/afk_pose.sv -----
// ----------------------------------------------------------------------------
// afk_pose
// Q1.16 rounding of sine and cosine, products, and the registered tool pose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afk_pose (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            vld_in,
	input  logic [afk_pkg::LANES-1:0]       neg_in,
	input  logic signed [afk_pkg::CW-1:0]   x_in [afk_pkg::LANES],
	input  logic signed [afk_pkg::CW-1:0]   y_in [afk_pkg::LANES],
	input  logic signed [afk_pkg::PW-1:0]   pz_in,
	input  afk_pkg::afk_cfg_t               cfg,
	output logic                            vld_s3,
	output logic signed [afk_pkg::QW-1:0]   rot_xx_s3,
	output logic signed [afk_pkg::QW-1:0]   rot_xy_s3,
	output logic signed [afk_pkg::QW-1:0]   rot_xz_s3,
	output logic signed [afk_pkg::QW-1:0]   rot_yx_s3,
	output logic signed [afk_pkg::QW-1:0]   rot_yy_s3,
	output logic signed [afk_pkg::QW-1:0]   rot_yz_s3,
	output logic signed [afk_pkg::QW-1:0]   rot_zy_s3,
	output logic signed [afk_pkg::QW-1:0]   rot_zz_s3,
	output logic signed [afk_pkg::PW-1:0]   pos_x_s3,
	output logic signed [afk_pkg::PW-1:0]   pos_y_s3,
	output logic signed [afk_pkg::PW-1:0]   pos_z_s3
);
	import afk_pkg::*;

	logic                  vld_s1, vld_s2;
	logic signed [QW-1:0]  sn_s1 [LANES];
	logic signed [QW-1:0]  cs_s1 [LANES];
	logic signed [PW-1:0]  pz_s1, pz_s2;
	logic signed [QW-1:0]  s234_s2, c234_s2, s5_s2, c5_s2;
	logic signed [RPW-1:0] cc_s2, cs_s2, sc_s2, ss_s2;
	logic signed [MW-1:0]  fx_s2, ux_s2, tx_s2, fy_s2, uy_s2, ty_s2;
	logic signed [SW-1:0]  sum_x, sum_y;

	function automatic logic signed [QW-1:0] to_q16(input logic signed [CW-1:0] v,
		input logic neg);
		logic signed [CW-1:0] t;
		logic signed [QW-1:0] r;
		t = (v + CRD_HALF) >>> 14;
		if (t > Q16_MAX) t = Q16_MAX;
		if (t < Q16_MIN) t = Q16_MIN;
		r = t[QW-1:0];
		return neg ? -r : r;
	endfunction

	function automatic logic signed [QW-1:0] rnd_rp(input logic signed [RPW-1:0] p);
		logic signed [RPW-1:0] t;
		t = (p + RND_RP) >>> 16;
		return t[QW-1:0];
	endfunction

	function automatic logic signed [PW-1:0] rnd_pos(input logic signed [SW-1:0] p);
		logic signed [SW-1:0] t;
		t = (p + RND_SUM) >>> 16;
		if (t > POS_MAX) t = POS_MAX;
		if (t < POS_MIN) t = POS_MIN;
		return t[PW-1:0];
	endfunction

	assign sum_x = SW'(fx_s2) + SW'(ux_s2) + SW'(tx_s2);
	assign sum_y = SW'(fy_s2) + SW'(uy_s2) - SW'(ty_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				sn_s1[l] <= to_q16(y_in[l], neg_in[l]);
				cs_s1[l] <= to_q16(x_in[l], neg_in[l]);
			end
			pz_s1 <= pz_in;

			s234_s2 <= sn_s1[L_T234];
			c234_s2 <= cs_s1[L_T234];
			s5_s2   <= sn_s1[L_T5];
			c5_s2   <= cs_s1[L_T5];
			cc_s2   <= RPW'(cs_s1[L_T234]) * RPW'(cs_s1[L_T5]);
			cs_s2   <= RPW'(cs_s1[L_T234]) * RPW'(sn_s1[L_T5]);
			sc_s2   <= RPW'(sn_s1[L_T234]) * RPW'(cs_s1[L_T5]);
			ss_s2   <= RPW'(sn_s1[L_T234]) * RPW'(sn_s1[L_T5]);
			fx_s2   <= MW'(cfg.fore) * MW'(cs_s1[L_T23]);
			ux_s2   <= MW'(cfg.upper) * MW'(cs_s1[L_T2]);
			tx_s2   <= MW'(cfg.tool) * MW'(sn_s1[L_T234]);
			fy_s2   <= MW'(cfg.fore) * MW'(sn_s1[L_T23]);
			uy_s2   <= MW'(cfg.upper) * MW'(sn_s1[L_T2]);
			ty_s2   <= MW'(cfg.tool) * MW'(cs_s1[L_T234]);
			pz_s2   <= pz_s1;

			rot_xx_s3 <= s234_s2;
			rot_xy_s3 <= rnd_rp(cc_s2);
			rot_xz_s3 <= -rnd_rp(cs_s2);
			rot_yx_s3 <= -c234_s2;
			rot_yy_s3 <= rnd_rp(sc_s2);
			rot_yz_s3 <= -rnd_rp(ss_s2);
			rot_zy_s3 <= s5_s2;
			rot_zz_s3 <= c5_s2;
			pos_x_s3  <= rnd_pos(sum_x);
			pos_y_s3  <= rnd_pos(sum_y);
			pos_z_s3  <= pz_s2;
		end
	end

endmodule

// ----- hw/rtl/arm_forward_kinematics_5axis_top.sv -----
// A request passes through the prep, CORDIC and pose register stages to the result.
// Throughput: one request per cycle while the pipe is not held; the whole pipe advances together.
// The pipe holds while the output register is full and stalled.
// Reset: asynchronous, clears all valid bits; link and offset registers
// return to zero, tool length to 100 mm.
// ----------------------------------------------------------------------------
// arm_forward_kinematics_5axis_top
// Five-axis arm forward kinematics: tool rotation and saturated position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arm_forward_kinematics_5axis_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [afk_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [afk_pkg::LW-1:0]               cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [afk_pkg::LW-1:0]        lift_height,
	input  logic signed [afk_pkg::IW-1:0]        shoulder_angle,
	input  logic signed [afk_pkg::IW-1:0]        elbow_angle,
	input  logic signed [afk_pkg::IW-1:0]        wrist_pitch_angle,
	input  logic signed [afk_pkg::IW-1:0]        wrist_roll_angle,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [afk_pkg::QW-1:0]        rot_xx,
	output logic signed [afk_pkg::QW-1:0]        rot_xy,
	output logic signed [afk_pkg::QW-1:0]        rot_xz,
	output logic signed [afk_pkg::QW-1:0]        rot_yx,
	output logic signed [afk_pkg::QW-1:0]        rot_yy,
	output logic signed [afk_pkg::QW-1:0]        rot_yz,
	output logic signed [afk_pkg::QW-1:0]        rot_zx,
	output logic signed [afk_pkg::QW-1:0]        rot_zy,
	output logic signed [afk_pkg::QW-1:0]        rot_zz,
	output logic signed [afk_pkg::PW-1:0]        pos_x,
	output logic signed [afk_pkg::PW-1:0]        pos_y,
	output logic signed [afk_pkg::PW-1:0]        pos_z
);
	import afk_pkg::*;

	afk_cfg_t             cfg_q;
	logic                 adv;
	logic                 vld_s2;
	afk_lane_t            lane_s2 [LANES];
	logic signed [PW-1:0] pz_s2;
	logic                 crd_vld;
	logic [LANES-1:0]     crd_neg;
	logic signed [CW-1:0] crd_x [LANES];
	logic signed [CW-1:0] crd_y [LANES];
	logic signed [PW-1:0] crd_pz;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign rot_zx   = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper  <= '0;
			cfg_q.fore   <= '0;
			cfg_q.height <= '0;
			cfg_q.tool   <= TOOL_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UPPER:  cfg_q.upper  <= cfg_data;
				REG_FORE:   cfg_q.fore   <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_TOOL:   cfg_q.tool   <= cfg_data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	afk_prep u_prep (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.in_take           (in_valid),
		.lift_height       (lift_height),
		.shoulder_angle    (shoulder_angle),
		.elbow_angle       (elbow_angle),
		.wrist_pitch_angle (wrist_pitch_angle),
		.wrist_roll_angle  (wrist_roll_angle),
		.height_offset     (cfg_q.height),
		.vld_s2            (vld_s2),
		.lane_s2           (lane_s2),
		.pz_s2             (pz_s2)
	);

	afk_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (vld_s2),
		.lane_in (lane_s2),
		.pz_in   (pz_s2),
		.vld_out (crd_vld),
		.neg_out (crd_neg),
		.x_out   (crd_x),
		.y_out   (crd_y),
		.pz_out  (crd_pz)
	);

	afk_pose u_pose (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_in    (crd_vld),
		.neg_in    (crd_neg),
		.x_in      (crd_x),
		.y_in      (crd_y),
		.pz_in     (crd_pz),
		.cfg       (cfg_q),
		.vld_s3    (out_valid),
		.rot_xx_s3 (rot_xx),
		.rot_xy_s3 (rot_xy),
		.rot_xz_s3 (rot_xz),
		.rot_yx_s3 (rot_yx),
		.rot_yy_s3 (rot_yy),
		.rot_yz_s3 (rot_yz),
		.rot_zy_s3 (rot_zy),
		.rot_zz_s3 (rot_zz),
		.pos_x_s3  (pos_x),
		.pos_y_s3  (pos_y),
		.pos_z_s3  (pos_z)
	);

	`AFK_ASSERT_IMPL(a_xx_range, out_valid, (rot_xx <= 18'sd65536) && (rot_xx >= -18'sd65536), "rot_xx out of Q1.16 range")
	`AFK_ASSERT_IMPL(a_zz_range, out_valid, (rot_zz <= 18'sd65536) && (rot_zz >= -18'sd65536), "rot_zz out of Q1.16 range")
	`AFK_ASSERT(a_hold_stalled, (out_valid && out_stall) |=> (out_valid && $stable(pos_x) && $stable(rot_xy)), "result changed while stalled")

endmodule
